// ===== hdl/plrp_pkg.sv =====
// Types, constants and register indexes shared by the frequency-table row parser.
package plrp_pkg;

   localparam int ROW_WORD_W   = 32;
   localparam int XO_RATE_W    = 27;
   localparam int CORES_W      = 3;
   localparam int DOMAIN_W     = 2;
   localparam int ROW_INDEX_W  = 5;
   localparam int FREQ_W       = 25;
   localparam int MULT_W       = 8;
   localparam int ROW_COUNT_W  = 6;
   localparam int TALLY_W      = 6;
   localparam int PROD_W       = XO_RATE_W + MULT_W;
   localparam int DIV_IN_W     = PROD_W - 3;
   localparam int QUOT_W       = 26;
   localparam int RECIP_W      = 26;

   localparam int MAX_ENTRIES  = 32;

   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = XO_RATE_W;

   localparam logic [CSR_INDEX_W-1:0] CSR_REF_RATE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_TURBO_CODE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOMAIN_ID  = 2'd2;

   localparam logic [XO_RATE_W-1:0] XO_RATE_RESET    = 27'd19200000;
   localparam logic [CORES_W-1:0]   TURBO_CODE_RESET = 3'd1;
   localparam logic [DOMAIN_W-1:0]  DOMAIN_ID_RESET  = 2'd0;

   localparam logic [FREQ_W-1:0]   FREQ_MAX    = '1;
   localparam logic [RECIP_W-1:0]  KHZ_RECIP   = 26'd34359738;
   localparam logic [DIV_IN_W-1:0] KHZ_DIV_ODD = 32'd125;

   typedef struct packed {
      logic [ROW_WORD_W-1:0] row_word;
      logic                  start_of_table;
   } req_payload_type;

   typedef struct packed {
      logic [DOMAIN_W-1:0]    domain_echo;
      logic [ROW_INDEX_W-1:0] row_index;
      logic [FREQ_W-1:0]      freq_khz;
      logic [CORES_W-1:0]     core_cnt;
      logic                   entry_valid;
      logic                   boost_promoted;
      logic                   end_of_table;
      logic                   row_ignored;
      logic [TALLY_W-1:0]     valid_total;
      logic                   table_usable;
   } rsp_payload_type;

endpackage

// ===== hdl/plrp_if.sv =====
// Row and result channel interfaces of the frequency-table row parser.
interface plrp_req_if import plrp_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface plrp_rsp_if import plrp_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;
   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

// ===== hdl/perf_lut_row_parser_core.sv =====
// Frequency-table row parser: decode rows, track table state, report each row.
//
// Rows arrive on req_if, one 32-bit row word per transfer with a start flag
// that restarts parsing at row zero. Each row yields exactly one result on
// rsp_if: decoded kHz, core count, entry flags, end and ignore flags and the
// running count of valid entries, tagged with the configured domain.
// The csr_ port writes the reference rate, turbo code and domain; write them
// only while no rows are in flight.
// Pipeline: each row passes the input register, product, reciprocal estimate,
// correction and table state registers before its result is offered.
// Throughput: one row per cycle while the receiver takes results; the table
// state update is combinational logic on the final stage.
// Reset clears the pipeline, the table state and loads register defaults.
// When the receiver stalls, the result register holds and empty stages
// keep filling; ready drops once all five stages hold rows.
module perf_lut_row_parser_core import plrp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   plrp_req_if.sink               req_if,
   plrp_rsp_if.source             rsp_if,
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata
);

   logic [XO_RATE_W-1:0] xo_rate_ff;
   logic [CORES_W-1:0]   turbo_code_ff;
   logic [DOMAIN_W-1:0]  domain_ff;

   logic s0_valid_ff, s1_valid_ff, s2_valid_ff, s3_valid_ff, rsp_valid_ff;
   logic s0_ready, s1_ready, s2_ready, s3_ready, rsp_ready;

   req_payload_type s0_data_ff;

   logic [PROD_W-1:0]   s1_prod_ff, s1_prod_in;
   logic [CORES_W-1:0]  s1_cores_ff;
   logic                s1_start_ff;

   logic [DIV_IN_W-1:0]         s2_x_ff, s2_x_in;
   logic [QUOT_W-1:0]           s2_q0_ff, s2_q0_in;
   logic [DIV_IN_W+RECIP_W-1:0] s2_est;
   logic [CORES_W-1:0]          s2_cores_ff;
   logic                        s2_start_ff;

   logic [DIV_IN_W-1:0] s2_rem;
   logic [QUOT_W-1:0]   s2_quot;
   logic [FREQ_W-1:0]   s3_freq_ff, s3_freq_in;
   logic [CORES_W-1:0]  s3_cores_ff;
   logic                s3_start_ff;

   logic [ROW_COUNT_W-1:0] next_row_ff, next_row_in;
   logic [FREQ_W-1:0]      last_freq_ff, last_freq_in;
   logic                   prior_turbo_ff, prior_turbo_in;
   logic [FREQ_W-1:0]      prior_turbo_freq_ff, prior_turbo_freq_in;
   logic [TALLY_W-1:0]     tally_ff, tally_in;
   logic                   done_ff, done_in;

   rsp_payload_type rsp_data_ff, rsp_data_in;

   // handshake: each stage advances when the next one is empty or advancing
   assign rsp_ready = !rsp_valid_ff || rsp_if.ready;
   assign s3_ready  = !s3_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign s0_ready  = !s0_valid_ff || s1_ready;

   assign req_if.ready   = s0_ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         xo_rate_ff    <= XO_RATE_RESET;
         turbo_code_ff <= TURBO_CODE_RESET;
         domain_ff     <= DOMAIN_ID_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_REF_RATE:   xo_rate_ff    <= csr_wdata;
            CSR_TURBO_CODE: turbo_code_ff <= csr_wdata[CORES_W-1:0];
            CSR_DOMAIN_ID:  domain_ff     <= csr_wdata[DOMAIN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (s0_ready)  s0_valid_ff  <= req_if.valid;
         if (s1_ready)  s1_valid_ff  <= s0_valid_ff;
         if (s2_ready)  s2_valid_ff  <= s1_valid_ff;
         if (s3_ready)  s3_valid_ff  <= s2_valid_ff;
         if (rsp_ready) rsp_valid_ff <= s3_valid_ff;
      end
   end

   // product stage: rate times multiplier, or the bare rate for source zero
   always_comb begin
      if (s0_data_ff.row_word[31:30] != 2'd0) begin
         s1_prod_in = PROD_W'(xo_rate_ff) * PROD_W'(s0_data_ff.row_word[MULT_W-1:0]);
      end else begin
         s1_prod_in = PROD_W'(xo_rate_ff);
      end
   end

   // divide by 1000 as divide by 8, then by 125 through a reciprocal estimate
   assign s2_x_in  = s1_prod_ff[PROD_W-1:3];
   assign s2_est   = (DIV_IN_W+RECIP_W)'(s2_x_in) * (DIV_IN_W+RECIP_W)'(KHZ_RECIP);
   assign s2_q0_in = s2_est[DIV_IN_W+QUOT_W-1:DIV_IN_W];

   // correct the estimate, which is low by at most one, then saturate
   assign s2_rem  = s2_x_ff - (DIV_IN_W'(s2_q0_ff) * KHZ_DIV_ODD);
   assign s2_quot = s2_q0_ff + QUOT_W'(s2_rem >= KHZ_DIV_ODD);
   assign s3_freq_in = s2_quot[QUOT_W-1] ? FREQ_MAX : s2_quot[FREQ_W-1:0];

   always_ff @(posedge clock) begin
      if (s0_ready && req_if.valid) begin
         s0_data_ff <= req_if.payload;
      end
      if (s1_ready && s0_valid_ff) begin
         s1_prod_ff  <= s1_prod_in;
         s1_cores_ff <= s0_data_ff.row_word[18:16];
         s1_start_ff <= s0_data_ff.start_of_table;
      end
      if (s2_ready && s1_valid_ff) begin
         s2_x_ff     <= s2_x_in;
         s2_q0_ff    <= s2_q0_in;
         s2_cores_ff <= s1_cores_ff;
         s2_start_ff <= s1_start_ff;
      end
      if (s3_ready && s2_valid_ff) begin
         s3_freq_ff  <= s3_freq_in;
         s3_cores_ff <= s2_cores_ff;
         s3_start_ff <= s2_start_ff;
      end
      if (rsp_ready && s3_valid_ff) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   // table state: restart on the start flag, then classify the row
   always_comb begin
      logic [ROW_COUNT_W-1:0] e_next;
      logic [FREQ_W-1:0]      e_last;
      logic                   e_prior;
      logic [FREQ_W-1:0]      e_prior_freq;
      logic [TALLY_W-1:0]     e_tally;
      logic                   e_done;
      logic                   valid, boost, ended;

      e_next       = s3_start_ff ? '0 : next_row_ff;
      e_last       = s3_start_ff ? '0 : last_freq_ff;
      e_prior      = s3_start_ff ? 1'b0 : prior_turbo_ff;
      e_prior_freq = s3_start_ff ? '0 : prior_turbo_freq_ff;
      e_tally      = s3_start_ff ? '0 : tally_ff;
      e_done       = s3_start_ff ? 1'b0 : done_ff;
      valid        = 1'b0;
      boost        = 1'b0;
      ended        = 1'b0;

      next_row_in         = e_next;
      last_freq_in        = e_last;
      prior_turbo_in      = e_prior;
      prior_turbo_freq_in = e_prior_freq;
      tally_in            = e_tally;
      done_in             = e_done;

      if (!e_done) begin
         if (s3_cores_ff == turbo_code_ff) begin
            prior_turbo_in      = 1'b1;
            prior_turbo_freq_in = s3_freq_ff;
         end else if (e_next != '0 && s3_freq_ff == e_last) begin
            if (e_prior && e_prior_freq == e_last) begin
               boost    = 1'b1;
               tally_in = e_tally + TALLY_W'(1);
            end
            ended          = 1'b1;
            prior_turbo_in = 1'b0;
         end else begin
            if (s3_freq_ff != e_last) begin
               valid    = 1'b1;
               tally_in = e_tally + TALLY_W'(1);
            end
            last_freq_in   = s3_freq_ff;
            prior_turbo_in = 1'b0;
         end
         next_row_in = e_next + ROW_COUNT_W'(1);
         if (e_next == ROW_COUNT_W'(MAX_ENTRIES - 1)) begin
            ended = 1'b1;
         end
         done_in = ended;
      end

      rsp_data_in.domain_echo    = domain_ff;
      rsp_data_in.row_index      = e_done ? '0 : e_next[ROW_INDEX_W-1:0];
      rsp_data_in.freq_khz       = s3_freq_ff;
      rsp_data_in.core_cnt       = s3_cores_ff;
      rsp_data_in.entry_valid    = valid;
      rsp_data_in.boost_promoted = boost;
      rsp_data_in.end_of_table   = ended;
      rsp_data_in.row_ignored    = e_done;
      rsp_data_in.valid_total    = tally_in;
      rsp_data_in.table_usable   = (tally_in != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_row_ff         <= '0;
         last_freq_ff        <= '0;
         prior_turbo_ff      <= 1'b0;
         prior_turbo_freq_ff <= '0;
         tally_ff            <= '0;
         done_ff             <= 1'b0;
      end else if (rsp_ready && s3_valid_ff) begin
         next_row_ff         <= next_row_in;
         last_freq_ff        <= last_freq_in;
         prior_turbo_ff      <= prior_turbo_in;
         prior_turbo_freq_ff <= prior_turbo_freq_in;
         tally_ff            <= tally_in;
         done_ff             <= done_in;
      end
   end

   a_tally_within_rows: assert property (@(posedge clock) disable iff (reset)
      tally_ff <= TALLY_W'(next_row_ff))
      else $error("valid entry count exceeds rows parsed");

   a_open_table_bounded: assert property (@(posedge clock) disable iff (reset)
      !done_ff |-> next_row_ff < ROW_COUNT_W'(MAX_ENTRIES))
      else $error("table still open past the last row");

   a_ignored_no_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.row_ignored |->
         !rsp_data_ff.entry_valid && !rsp_data_ff.boost_promoted &&
         !rsp_data_ff.end_of_table)
      else $error("ignored row carries entry flags");

   a_boost_ends_table: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.boost_promoted |->
         rsp_data_ff.end_of_table && !rsp_data_ff.entry_valid)
      else $error("boost promotion without end of table");

endmodule
